/* hw/rtl/timestamped_event_to_sample_packer_top_macros.svh */
// Assertion helpers for the sample packer.
// Both check on the rising edge of i_clk and stay quiet while i_rst_n is low.
`ifndef TIMESTAMPED_EVENT_TO_SAMPLE_PACKER_TOP_MACROS_SVH
`define TIMESTAMPED_EVENT_TO_SAMPLE_PACKER_TOP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define TESP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define TESP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/tesp_pkg.sv */
`default_nettype none

package tesp_pkg;

    localparam int BLOCK_SAMPLES  = 64;
    localparam int LEVEL_CHANNELS = 5;
    localparam int WORD_W         = 64;
    localparam int FILL_W         = $clog2(BLOCK_SAMPLES);
    localparam int CNT_W          = FILL_W + 1;

    localparam int MS_W     = 32;
    localparam int TICK_W   = 16;
    localparam int PORT_W   = 16;
    localparam int SPM_W    = 20;
    localparam int NS_W     = 40;
    localparam int POS_W    = 64;
    localparam int PROD_W   = MS_W + SPM_W;
    localparam int LVL_LSB  = 3;
    localparam int KIND_W   = 1;
    localparam int RLVL_W   = 5;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 40;

    localparam int IN_DATA_W   = MS_W + TICK_W + PORT_W;
    localparam int OUT_PAY_W   = RLVL_W + NS_W + LEVEL_CHANNELS * WORD_W;
    localparam int OUT_DATA_W  = ((OUT_PAY_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_PAY_W;

    localparam logic [SPM_W-1:0] SPM_RESET = 20'd1000;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_MS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SAMPLES  = 1'd1;

    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic KIND_RUN   = 1'b0;
    localparam logic KIND_BLOCK = 1'b1;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // work handed from the front to the back
    typedef struct packed {
        logic                      flush;
        logic [LEVEL_CHANNELS-1:0] lvl;
        logic [NS_W-1:0]           n;
    } t_cmd;

    typedef logic [LEVEL_CHANNELS-1:0][WORD_W-1:0] t_chan_bits;

    typedef struct packed {
        logic              kind;
        logic [RLVL_W-1:0] run_level;
        logic [NS_W-1:0]   run_samples;
        t_chan_bits        chan;
        logic              last;
    } t_result;

    // samples_per_ms * 0xFFFFFFFF without a multiplier
    function automatic logic [PROD_W-1:0] wrap_step(input logic [SPM_W-1:0] spm);
        return {spm, {MS_W{1'b0}}} - PROD_W'(spm);
    endfunction

    // shift k samples of one channel level into the low end of a block word
    function automatic logic [WORD_W-1:0] append_bits(input logic [WORD_W-1:0] bits,
                                                      input logic lvl_bit,
                                                      input logic [CNT_W-1:0] k);
        return (bits << k) | ({WORD_W{lvl_bit}} & ~({WORD_W{1'b1}} << k));
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/tesp_front.sv */
`default_nettype none

module tesp_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tesp_pkg::t_cfg_wr                    i_cfg,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_op,
    input  logic [tesp_pkg::MS_W-1:0]            i_ms,
    input  logic [tesp_pkg::TICK_W-1:0]          i_tick,
    input  logic [tesp_pkg::PORT_W-1:0]          i_port,
    output logic                                 o_push,
    output tesp_pkg::t_cmd                       o_cmd,
    input  logic                                 i_q_ready
);

    typedef enum logic [3:0] {
        ST_SUM   = 4'b0001,
        ST_CMP   = 4'b0010,
        ST_GAP   = 4'b0100,
        ST_ISSUE = 4'b1000
    } t_state;

    // input register
    logic                                  r_a_valid;
    logic                                  r_a_op;
    logic [tesp_pkg::MS_W-1:0]             r_a_ms;
    logic [tesp_pkg::TICK_W-1:0]           r_a_tick;
    logic [tesp_pkg::LEVEL_CHANNELS-1:0]   r_a_lvl;

    // product register, the sequencer works on this item
    logic                                  r_b_valid;
    logic                                  r_b_op;
    logic [tesp_pkg::PROD_W-1:0]           r_b_prod;
    logic [tesp_pkg::TICK_W-1:0]           r_b_tick;
    logic [tesp_pkg::LEVEL_CHANNELS-1:0]   r_b_lvl;

    t_state                                r_state, n_state;
    logic [tesp_pkg::POS_W-1:0]            r_wrap, n_wrap;
    logic [tesp_pkg::POS_W-1:0]            r_pos, n_pos;
    logic [tesp_pkg::POS_W-1:0]            r_t, n_t;
    logic [tesp_pkg::POS_W-1:0]            r_gap, n_gap;
    logic [tesp_pkg::LEVEL_CHANNELS-1:0]   r_level, n_level;
    logic                                  r_have, n_have;
    logic [tesp_pkg::NS_W-1:0]             r_rem, n_rem;
    logic [tesp_pkg::SPM_W-1:0]            r_spm;
    logic [tesp_pkg::PROD_W-1:0]           r_wadd;

    logic                                  w_in_xfer;
    logic                                  w_a_adv;
    logic                                  w_b_done;
    logic [tesp_pkg::PROD_W-1:0]           w_prod;
    logic [tesp_pkg::POS_W-1:0]            w_t_sum;
    logic                                  w_lt;
    logic [tesp_pkg::POS_W:0]              w_diff;
    logic                                  w_gap_lt;
    logic [tesp_pkg::NS_W-1:0]             w_n;

    assign w_prod   = r_a_ms * r_spm;
    assign w_t_sum  = tesp_pkg::POS_W'(r_b_prod) + tesp_pkg::POS_W'(r_b_tick) + r_wrap;
    assign w_lt     = r_t < r_pos;
    assign w_diff   = {1'b0, r_t} - {1'b0, r_pos};
    assign w_gap_lt = r_gap < tesp_pkg::POS_W'(r_rem);
    assign w_n      = w_gap_lt ? r_gap[tesp_pkg::NS_W-1:0] : r_rem;

    always_comb begin
        n_state  = r_state;
        n_wrap   = r_wrap;
        n_pos    = r_pos;
        n_t      = r_t;
        n_gap    = r_gap;
        n_level  = r_level;
        n_have   = r_have;
        n_rem    = r_rem;
        o_push   = 1'b0;
        o_cmd    = '0;
        w_b_done = 1'b0;
        if (r_b_valid) begin
            case (r_state)
                ST_SUM: begin
                    if (r_b_op == tesp_pkg::OP_FLUSH) begin
                        if (!r_have) begin
                            w_b_done = 1'b1;
                        end else if (i_q_ready) begin
                            o_push      = 1'b1;
                            o_cmd.flush = 1'b1;
                            o_cmd.lvl   = r_level;
                            o_cmd.n     = r_rem;
                            n_rem       = '0;
                            w_b_done    = 1'b1;
                        end
                    end else if (!r_have) begin
                        n_have   = 1'b1;
                        n_level  = r_b_lvl;
                        n_pos    = w_t_sum;
                        w_b_done = 1'b1;
                    end else if (r_b_lvl == r_level) begin
                        w_b_done = 1'b1;
                    end else begin
                        n_t     = w_t_sum;
                        n_state = ST_CMP;
                    end
                end
                ST_CMP: begin
                    // tick went backwards: assume the ms counter wrapped
                    if (w_lt) begin
                        n_t    = r_t + tesp_pkg::POS_W'(r_wadd);
                        n_wrap = r_wrap + tesp_pkg::POS_W'(r_wadd);
                    end
                    n_state = ST_GAP;
                end
                ST_GAP: begin
                    if (w_diff[tesp_pkg::POS_W]) begin
                        n_gap = '0;
                    end else begin
                        n_gap = w_diff[tesp_pkg::POS_W-1:0];
                        n_pos = r_t;
                    end
                    n_state = ST_ISSUE;
                end
                ST_ISSUE: begin
                    if ((w_n == '0) || i_q_ready) begin
                        o_push      = (w_n != '0);
                        o_cmd.flush = 1'b0;
                        o_cmd.lvl   = r_level;
                        o_cmd.n     = w_n;
                        n_rem       = w_gap_lt ? (r_rem - r_gap[tesp_pkg::NS_W-1:0]) : '0;
                        n_level     = r_b_lvl;
                        n_state     = ST_SUM;
                        w_b_done    = 1'b1;
                    end
                end
                default: begin
                    n_state = ST_SUM;
                end
            endcase
        end
        // writing the capture length reloads what is left of it
        if (i_cfg.we && (i_cfg.idx == tesp_pkg::REG_TOTAL_SAMPLES)) begin
            n_rem = i_cfg.data[tesp_pkg::NS_W-1:0];
        end
    end

    assign w_a_adv   = r_a_valid && (!r_b_valid || w_b_done);
    assign o_ready   = !r_a_valid || w_a_adv;
    assign w_in_xfer = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_state   <= ST_SUM;
            r_wrap    <= '0;
            r_pos     <= '0;
            r_level   <= '0;
            r_have    <= 1'b0;
            r_rem     <= '0;
            r_spm     <= tesp_pkg::SPM_RESET;
            r_wadd    <= tesp_pkg::wrap_step(tesp_pkg::SPM_RESET);
        end else begin
            if (w_in_xfer) begin
                r_a_valid <= 1'b1;
            end else if (w_a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (w_a_adv) begin
                r_b_valid <= 1'b1;
            end else if (w_b_done) begin
                r_b_valid <= 1'b0;
            end
            r_state <= n_state;
            r_wrap  <= n_wrap;
            r_pos   <= n_pos;
            r_level <= n_level;
            r_have  <= n_have;
            r_rem   <= n_rem;
            if (i_cfg.we) begin
                case (i_cfg.idx)
                    tesp_pkg::REG_SAMPLES_PER_MS: begin
                        r_spm  <= i_cfg.data[tesp_pkg::SPM_W-1:0];
                        r_wadd <= tesp_pkg::wrap_step(i_cfg.data[tesp_pkg::SPM_W-1:0]);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_a_op   <= i_op;
            r_a_ms   <= i_ms;
            r_a_tick <= i_tick;
            r_a_lvl  <= i_port[tesp_pkg::LVL_LSB +: tesp_pkg::LEVEL_CHANNELS];
        end
        if (w_a_adv) begin
            r_b_op   <= r_a_op;
            r_b_prod <= w_prod;
            r_b_tick <= r_a_tick;
            r_b_lvl  <= r_a_lvl;
        end
        r_t   <= n_t;
        r_gap <= n_gap;
    end

endmodule

`default_nettype wire

/* hw/rtl/tesp_queue.sv */
`default_nettype none

module tesp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tesp_pkg::t_cmd i_cmd,
    output logic           o_ready,
    output logic           o_valid,
    output tesp_pkg::t_cmd o_cmd,
    input  logic           i_pop
);

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    tesp_pkg::t_cmd    r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_AW:0]     r_count;

    logic w_push;
    logic w_pop;

    assign o_ready = r_count != (Q_AW + 1)'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + (Q_AW + 1)'(1);
                2'b01:   r_count <= r_count - (Q_AW + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/tesp_back.sv */
`default_nettype none

module tesp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  tesp_pkg::t_cmd    i_q_cmd,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output tesp_pkg::t_result o_res
);

    typedef enum logic [2:0] {
        PH_HEAD = 3'b001,
        PH_RUN  = 3'b010,
        PH_TAIL = 3'b100
    } t_phase;

    logic                                 r_busy, n_busy;
    t_phase                               r_phase, n_phase;
    logic                                 r_flush, n_flush;
    logic [tesp_pkg::LEVEL_CHANNELS-1:0]  r_lvl, n_lvl;
    logic [tesp_pkg::NS_W-1:0]            r_n, n_n;
    logic [tesp_pkg::FILL_W-1:0]          r_pfill, n_pfill;
    tesp_pkg::t_chan_bits                 r_bits, n_bits;
    logic                                 r_out_valid;
    tesp_pkg::t_result                    r_out;

    logic                                 w_out_free;
    logic [tesp_pkg::CNT_W-1:0]           w_p;
    logic [tesp_pkg::CNT_W-1:0]           w_room;
    logic                                 w_head_act;
    logic                                 w_n_small;
    logic [tesp_pkg::CNT_W-1:0]           w_k;
    logic [tesp_pkg::NS_W-1:0]            w_n_left;
    logic                                 w_head_full;
    logic                                 w_run;
    logic [tesp_pkg::FILL_W-1:0]          w_tail;
    logic                                 w_tail_emit;
    tesp_pkg::t_chan_bits                 w_head_bits;
    tesp_pkg::t_chan_bits                 w_pad_bits;
    tesp_pkg::t_chan_bits                 w_tail_bits;
    logic                                 w_emit;
    logic                                 w_fin;
    logic                                 w_take;
    tesp_pkg::t_result                    w_res;

    assign w_out_free  = !r_out_valid || i_ready;
    assign w_p         = tesp_pkg::CNT_W'(r_pfill);
    assign w_room      = tesp_pkg::CNT_W'(tesp_pkg::BLOCK_SAMPLES) - w_p;
    assign w_head_act  = (r_pfill != '0) && (r_n != '0);
    assign w_n_small   = r_n < tesp_pkg::NS_W'(w_room);
    assign w_k         = w_n_small ? r_n[tesp_pkg::CNT_W-1:0] : w_room;
    assign w_n_left    = r_n - tesp_pkg::NS_W'(w_k);
    assign w_head_full = w_head_act && !w_n_small;
    assign w_run       = r_n[tesp_pkg::NS_W-1:tesp_pkg::FILL_W] != '0;
    assign w_tail      = r_n[tesp_pkg::FILL_W-1:0];
    assign w_tail_emit = r_flush && ((r_pfill != '0) || (w_tail != '0));

    // padding appends the tail and the pad with one level, so one shift by the room covers both
    always_comb begin
        for (int c = 0; c < tesp_pkg::LEVEL_CHANNELS; c++) begin
            w_head_bits[c] = tesp_pkg::append_bits(r_bits[c], r_lvl[c], w_k);
            w_pad_bits[c]  = tesp_pkg::append_bits(r_bits[c], r_lvl[c], w_room);
            w_tail_bits[c] = tesp_pkg::append_bits(r_bits[c], r_lvl[c],
                                                   tesp_pkg::CNT_W'(w_tail));
        end
    end

    always_comb begin
        n_busy  = r_busy;
        n_phase = r_phase;
        n_flush = r_flush;
        n_lvl   = r_lvl;
        n_n     = r_n;
        n_pfill = r_pfill;
        n_bits  = r_bits;
        w_emit  = 1'b0;
        w_fin   = 1'b0;
        w_res   = '0;
        if (r_busy) begin
            case (r_phase)
                PH_HEAD: begin
                    if (w_head_full) begin
                        if (w_out_free) begin
                            w_emit     = 1'b1;
                            w_res.kind = tesp_pkg::KIND_BLOCK;
                            w_res.chan = w_head_bits;
                            w_res.last = (w_n_left[tesp_pkg::NS_W-1:tesp_pkg::FILL_W] == '0) &&
                                         !(r_flush && (w_n_left != '0));
                            n_bits     = '0;
                            n_pfill    = '0;
                            n_n        = w_n_left;
                            n_phase    = PH_RUN;
                        end
                    end else begin
                        if (w_head_act) begin
                            n_bits  = w_head_bits;
                            n_pfill = tesp_pkg::FILL_W'(w_p + w_k);
                            n_n     = w_n_left;
                        end
                        n_phase = PH_RUN;
                    end
                end
                PH_RUN: begin
                    if (w_run) begin
                        if (w_out_free) begin
                            w_emit            = 1'b1;
                            w_res.kind        = tesp_pkg::KIND_RUN;
                            w_res.run_level   = tesp_pkg::RLVL_W'(r_lvl);
                            w_res.run_samples = {r_n[tesp_pkg::NS_W-1:tesp_pkg::FILL_W],
                                                 {tesp_pkg::FILL_W{1'b0}}};
                            w_res.last        = !(r_flush && (w_tail != '0));
                            n_n               = tesp_pkg::NS_W'(w_tail);
                            n_phase           = PH_TAIL;
                        end
                    end else begin
                        n_phase = PH_TAIL;
                    end
                end
                PH_TAIL: begin
                    if (w_tail_emit) begin
                        if (w_out_free) begin
                            w_emit     = 1'b1;
                            w_res.kind = tesp_pkg::KIND_BLOCK;
                            w_res.chan = w_pad_bits;
                            w_res.last = 1'b1;
                            n_bits     = '0;
                            n_pfill    = '0;
                            w_fin      = 1'b1;
                        end
                    end else begin
                        if (!r_flush) begin
                            n_bits  = w_tail_bits;
                            n_pfill = tesp_pkg::FILL_W'(w_p + tesp_pkg::CNT_W'(w_tail));
                        end
                        w_fin = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_HEAD;
                end
            endcase
        end
        w_take = i_q_valid && (!r_busy || w_fin);
        if (w_take) begin
            n_busy  = 1'b1;
            n_flush = i_q_cmd.flush;
            n_lvl   = i_q_cmd.lvl;
            n_n     = i_q_cmd.n;
            n_phase = PH_HEAD;
        end else if (w_fin) begin
            n_busy = 1'b0;
        end
    end

    assign o_q_pop = w_take;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_HEAD;
            r_pfill     <= '0;
            r_bits      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_phase <= n_phase;
            r_pfill <= n_pfill;
            r_bits  <= n_bits;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_flush <= n_flush;
        r_lvl   <= n_lvl;
        r_n     <= n_n;
        if (w_emit) begin
            r_out <= w_res;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/timestamped_event_to_sample_packer_top.sv */
// channel   dir  handshake                         payload
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready  tdata: event fields, tuser: opcode
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready  tdata: result fields, tuser: kind, tlast
// cfg       in   i_cfg_we                           i_cfg_idx, i_cfg_wdata
//
// A change event steps through the front sequencer states (sum, wrap check, gap, issue);
// the 32x20 multiply sits in its own stage and overlaps the previous event. Flushes,
// first events and repeated levels finish in the sum state; a flush may wait there for queue room.
// The back steps through head, run and tail per queued command, one result at most each.
// A 4-entry command queue and the output register let either side stall alone.
// Reset is synchronous; registers return to 1000 samples/ms and an empty capture.
`default_nettype none

`include "timestamped_event_to_sample_packer_top_macros.svh"

module timestamped_event_to_sample_packer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tesp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tesp_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // event_ms, event_tick, raw_port
    input  logic [tesp_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // opcode
    input  logic [tesp_pkg::KIND_W-1:0]         i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // run_level, run_samples, chan0_bits, chan1_bits, chan2_bits, chan3_bits, chan4_bits
    output logic [tesp_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // kind
    output logic [tesp_pkg::KIND_W-1:0]         o_m_axis_tuser,
    output logic                                o_m_axis_tlast
);

    tesp_pkg::t_cfg_wr  w_cfg;
    logic               w_push;
    tesp_pkg::t_cmd     w_push_cmd;
    logic               w_q_ready;
    logic               w_q_valid;
    tesp_pkg::t_cmd     w_q_cmd;
    logic               w_q_pop;
    tesp_pkg::t_result  w_res;
    logic               w_out_run;
    logic               w_run_whole;

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.idx  = i_cfg_idx;
    assign w_cfg.data = i_cfg_wdata;

    tesp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_op      (i_s_axis_tuser[0]),
        .i_ms      (i_s_axis_tdata[tesp_pkg::MS_W-1:0]),
        .i_tick    (i_s_axis_tdata[tesp_pkg::MS_W +: tesp_pkg::TICK_W]),
        .i_port    (i_s_axis_tdata[tesp_pkg::MS_W + tesp_pkg::TICK_W +: tesp_pkg::PORT_W]),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd),
        .i_q_ready (w_q_ready)
    );

    tesp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_q_pop)
    );

    tesp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_q_cmd),
        .o_q_pop   (w_q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_res     (w_res)
    );

    assign o_m_axis_tdata = {{tesp_pkg::OUT_PAD_W{1'b0}}, w_res.chan, w_res.run_samples,
                             w_res.run_level};
    assign o_m_axis_tuser = w_res.kind;
    assign o_m_axis_tlast = w_res.last;

    assign w_out_run   = o_m_axis_tvalid && (o_m_axis_tuser[0] == tesp_pkg::KIND_RUN);
    assign w_run_whole = (w_res.run_samples[tesp_pkg::FILL_W-1:0] == '0) &&
                         (w_res.run_samples != '0);

    `TESP_ASSERT_NOW(a_q_no_overflow, w_push, w_q_ready, "command issued into a full queue")
    `TESP_ASSERT_NEXT(a_q_keeps_cmd, w_push && !w_q_pop, w_q_valid, "queued command vanished")
    `TESP_ASSERT_NOW(a_run_whole_blocks, w_out_run, w_run_whole, "run not whole blocks")

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps

import tesp_pkg::*;

// Scoreboard: tracks the packer's state, predicts the results of each accepted event
// and checks the results that come out of the block against them in order.
class packer_scoreboard;
    bit [63:0]   spm;
    bit [63:0]   wrap_offset;
    bit [63:0]   position;
    bit [63:0]   remaining;
    bit [4:0]    level;
    bit          have_level;
    int unsigned fill;
    bit [63:0]   block_bits [LEVEL_CHANNELS];
    t_result     due_results [$];
    int          errors;
    int          inputs_seen;
    int          runs_seen;
    int          blocks_seen;

    function new();
        spm         = 64'(SPM_RESET);
        wrap_offset = '0;
        position    = '0;
        remaining   = '0;
        level       = '0;
        have_level  = 1'b0;
        fill        = 0;
        foreach (block_bits[c]) block_bits[c] = '0;
        errors      = 0;
        inputs_seen = 0;
        runs_seen   = 0;
        blocks_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        if (idx == REG_SAMPLES_PER_MS) begin
            spm = 64'(value[SPM_W-1:0]);
        end else if (idx == REG_TOTAL_SAMPLES) begin
            remaining = 64'(value[NS_W-1:0]);
        end
    endfunction

    function void push_result(logic kind, bit [4:0] lvl, bit [63:0] samples);
        t_result r;
        r = '0;
        r.kind = kind;
        if (kind == KIND_RUN) begin
            r.run_level   = lvl;
            r.run_samples = samples[NS_W-1:0];
        end else begin
            for (int c = 0; c < LEVEL_CHANNELS; c++) r.chan[c] = block_bits[c];
        end
        due_results.push_back(r);
    endfunction

    // shift k samples (1..64) of one level into the open block
    function void append(bit [4:0] lvl, int unsigned k);
        bit [63:0] ones;
        ones = (k >= 64) ? '1 : ((64'd1 << k) - 64'd1);
        for (int c = 0; c < LEVEL_CHANNELS; c++)
            block_bits[c] = ((k >= 64) ? 64'd0 : (block_bits[c] << k)) |
                            (lvl[c] ? ones : 64'd0);
        fill += k;
    endfunction

    function void emit_block();
        push_result(KIND_BLOCK, 5'd0, 64'd0);
        foreach (block_bits[c]) block_bits[c] = '0;
        fill = 0;
    endfunction

    // close the open block, then whole blocks as one run, rest opens a new block
    function void place(bit [4:0] lvl, bit [63:0] n);
        bit [63:0] k;
        bit [63:0] run;
        if (fill > 0 && n > 0) begin
            k = (n < 64'(BLOCK_SAMPLES - fill)) ? n : 64'(BLOCK_SAMPLES - fill);
            append(lvl, 32'(k));
            n -= k;
            if (fill >= BLOCK_SAMPLES) emit_block();
        end
        if (n >= 64'(BLOCK_SAMPLES)) begin
            run = n - (n % 64'(BLOCK_SAMPLES));
            push_result(KIND_RUN, lvl, run);
            n -= run;
        end
        if (n > 0) append(lvl, 32'(n));
    endfunction

    function void take_event(logic op, logic [MS_W-1:0] ms, logic [TICK_W-1:0] tick,
                             logic [PORT_W-1:0] port);
        bit [63:0] t;
        bit [63:0] gap;
        bit [63:0] n;
        bit [63:0] wrap_step;
        bit [4:0]  lvl;
        int        queued;
        queued = due_results.size();
        inputs_seen++;
        if (op == OP_FLUSH) begin
            if (have_level) begin
                place(level, remaining);
                remaining = '0;
                if (fill > 0) begin
                    append(level, BLOCK_SAMPLES - fill);
                    emit_block();
                end
            end
        end else begin
            lvl = port[LVL_LSB +: LEVEL_CHANNELS];
            t = 64'(ms) * spm + 64'(tick) + wrap_offset;
            if (!have_level) begin
                have_level = 1'b1;
                level      = lvl;
                position   = t;
            end else if (lvl != level) begin
                // tick went backwards: assume the millisecond counter wrapped
                if (t < position) begin
                    wrap_step = 64'h0000_0000_FFFF_FFFF * spm;
                    t += wrap_step;
                    wrap_offset += wrap_step;
                end
                gap = (t > position) ? t - position : 64'd0;
                n = (gap < remaining) ? gap : remaining;
                place(level, n);
                remaining -= n;
                if (t > position) position = t;
                level = lvl;
            end
        end
        if (due_results.size() > queued) due_results[due_results.size() - 1].last = 1'b1;
    endfunction

    task report(string msg);
        errors++;
        $display("tb: mismatch #%0d: %s", errors, msg);
    endtask

    task check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want) report($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task check_result(logic kind, logic [OUT_DATA_W-1:0] data, logic last);
        t_result want;
        if (due_results.size() == 0) begin
            report($sformatf("result with none pending, kind %0d", kind));
        end else begin
            want = due_results.pop_front();
            if (want.kind == KIND_RUN) runs_seen++;
            else blocks_seen++;
            check_field("kind", 64'(kind), 64'(want.kind));
            check_field("run_level", 64'(data[RLVL_W-1:0]), 64'(want.run_level));
            check_field("run_samples", 64'(data[RLVL_W +: NS_W]), 64'(want.run_samples));
            for (int c = 0; c < LEVEL_CHANNELS; c++)
                check_field($sformatf("chan%0d_bits", c),
                            data[RLVL_W + NS_W + c * WORD_W +: WORD_W], want.chan[c]);
            check_field("last", 64'(last), 64'(want.last));
        end
    endtask
endclass

module tb;

    localparam int LIMIT  = 400000;
    localparam int SETTLE = 48;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_STARVED} rx_mode_e;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic [KIND_W-1:0]     i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [KIND_W-1:0]     o_m_axis_tuser;
    logic                  o_m_axis_tlast;

    packer_scoreboard sb = new();

    int        cycle_count;
    bit [31:0] gen_ms;
    bit [15:0] gen_tick;
    bit [4:0]  gen_level;

    timestamped_event_to_sample_packer_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            sb.take_event(i_s_axis_tuser[0], i_s_axis_tdata[MS_W-1:0],
                          i_s_axis_tdata[MS_W +: TICK_W],
                          i_s_axis_tdata[MS_W + TICK_W +: PORT_W]);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tuser[0], o_m_axis_tdata, o_m_axis_tlast);
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: FAIL");
        $finish;
    end

    // output side backpressure, independent of the sender
    initial begin : receiver
        rx_mode_e    mode;
        int unsigned span;
        bit [15:0]   mask;
        int unsigned k;
        i_m_axis_tready <= 1'b0;
        forever begin
            mode = rx_mode_e'($urandom_range(0, 3));
            span = $urandom_range(16, 160);
            mask = 16'($urandom);
            k = 0;
            repeat (span) begin
                @(posedge i_clk);
                case (mode)
                    RX_OPEN:    i_m_axis_tready <= 1'b1;
                    RX_RANDOM:  i_m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_PATTERN: i_m_axis_tready <= mask[k % 16];
                    default:    i_m_axis_tready <= ($urandom_range(0, 7) == 0);
                endcase
                k++;
            end
        end
    end

    task automatic send_item(logic op, logic [MS_W-1:0] ms, logic [TICK_W-1:0] tick,
                             logic [PORT_W-1:0] port);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {port, tick, ms};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // leaves the write enable high; the caller drops it
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.write_reg(idx, value);
    endtask

    task automatic set_capture(logic [SPM_W-1:0] spm, logic [NS_W-1:0] total);
        cfg_write(REG_SAMPLES_PER_MS, CFG_DATA_W'(spm));
        cfg_write(REG_TOTAL_SAMPLES, total);
        i_cfg_we <= 1'b0;
    endtask

    // stop sending, let every pending result drain, then allow for silent work
    task automatic quiesce();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.due_results.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // restart the event clock at the packer's current position
    task automatic sync_to_position();
        bit [63:0] span;
        bit [63:0] whole;
        bit [63:0] rest;
        span  = (sb.position > sb.wrap_offset) ? sb.position - sb.wrap_offset : 64'd0;
        whole = span / sb.spm;
        rest  = span - whole * sb.spm;
        if (whole > 64'h0000_0000_FFFF_0000) begin
            gen_ms   = 32'hFFFF_0000;
            gen_tick = '0;
        end else if (rest > 64'd65535) begin
            gen_ms   = 32'(whole) + 32'd1;
            gen_tick = '0;
        end else begin
            gen_ms   = 32'(whole);
            gen_tick = 16'(rest);
        end
        gen_level = sb.level;
    endtask

    task automatic send_random_event(bit late);
        int unsigned pick;
        int unsigned d;
        int unsigned sum;
        bit [15:0]   port;
        pick = $urandom_range(0, 99);
        if (late && pick < 5) begin
            if (gen_ms != 0) gen_ms = gen_ms - 32'd1;
            else gen_tick = gen_tick >> 1;
        end else if (pick < 15) begin
            gen_ms = gen_ms + $urandom_range(1, 2);
        end else if (pick >= 25) begin
            d = (pick < 70) ? $urandom_range(1, 70) : $urandom_range(0, 400);
            sum = gen_tick + d;
            if (sum <= 65535) begin
                gen_tick = 16'(sum);
            end else if (sb.spm > 64'd70000) begin
                gen_ms   = gen_ms + 32'd1;
                gen_tick = 16'(d);
            end else begin
                gen_ms   = gen_ms + 32'(64'(sum) / sb.spm);
                gen_tick = 16'(64'(sum) % sb.spm);
            end
        end
        // otherwise same time stamp: a level change with no samples between
        if ($urandom_range(0, 99) >= 15) gen_level = 5'($urandom_range(0, 31));
        port = 16'($urandom);
        port[LVL_LSB +: LEVEL_CHANNELS] = gen_level;
        send_item(OP_EVENT, gen_ms, gen_tick, port);
    endtask

    task automatic run_phase(logic [SPM_W-1:0] spm, logic [NS_W-1:0] total, int items);
        int burst;
        int gap;
        int hold_at;
        set_capture(spm, total);
        sync_to_position();
        hold_at = $urandom_range(items / 4, 3 * items / 4);
        burst = 0;
        for (int i = 0; i < items; i++) begin
            if (i == hold_at) begin
                i_s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (sb.due_results.size() != 0);
            end else if (burst == 0) begin
                burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 8);
                gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    i_s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            if (i == items - 1) send_item(OP_FLUSH, $urandom, 16'($urandom), 16'($urandom));
            else send_random_event(i > 3 * items / 4);
            if (burst > 0) burst--;
        end
        quiesce();
    endtask

    task automatic run_directed();
        cfg_write(REG_TOTAL_SAMPLES, 40'd1_000_000);
        i_cfg_we <= 1'b0;
        send_item(OP_FLUSH, '1, '1, '1);                    // flush with no level yet
        send_item(OP_EVENT, 32'd0, 16'd0, 16'h0000);        // first event sets level only
        send_item(OP_EVENT, 32'd0, 16'd40, 16'h0007);       // same level, dropped
        send_item(OP_EVENT, 32'd0, 16'd10, 16'hFFFF);
        send_item(OP_EVENT, 32'd0, 16'd70, 16'h0028);       // closes a block
        send_item(OP_EVENT, 32'd1, 16'd500, 16'h00F8);      // block then run
        send_item(OP_EVENT, 32'd1, 16'd500, 16'h0008);      // no samples between
        send_item(OP_EVENT, 32'd1, 16'd563, 16'h0010);
        send_item(OP_EVENT, 32'd2, 16'hFFFF, 16'h0018);
        send_item(OP_EVENT, 32'd0, 16'd0, 16'h0020);        // backwards, uses up capture
        send_item(OP_EVENT, 32'd5, 16'd3, 16'h0030);        // capture gone: tracking only
        send_item(OP_FLUSH, 32'd0, 16'd0, 16'd0);
        quiesce();
        set_capture(20'd1_000_000, 40'hFF_FFFF_FFFF);
        send_item(OP_EVENT, 32'hFFFF_FFFF, 16'd100, 16'h0038);
        send_item(OP_EVENT, 32'd0, 16'd50, 16'h0040);       // still behind after wrap step
        send_item(OP_FLUSH, '0, '1, '0);
        quiesce();
        set_capture(20'd64, 40'd5000);
        send_item(OP_EVENT, 32'd10, 16'd0, 16'h0048);
        send_item(OP_EVENT, 32'd10, 16'd9, 16'hFF4F);       // same level, other bits set
        send_item(OP_EVENT, 32'd20, 16'd1, 16'h0050);
        send_item(OP_FLUSH, '1, '0, '1);                    // block, run, padded block
        quiesce();
    endtask

    initial begin : stimulus
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= REG_SAMPLES_PER_MS;
        i_cfg_wdata     <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= OP_EVENT;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_phase(20'd1000, 40'd1_000_000, 60);
        run_phase(20'd64, 40'hFF_FFFF_FFFF, 60);
        run_phase(20'd1_000_000, 40'hFF_FFFF_FFFF, 40);
        run_phase(20'd125, 40'd0, 10);
        run_phase(20'd48000, 40'd6000, 40);
        run_phase(20'($urandom_range(64, 1_000_000)),
                  {8'($urandom_range(1, 255)), 32'($urandom)}, 60);
        run_phase(20'd64, 40'd3000, 30);
        run_phase(20'd1000, 40'd1_000_000, 60);

        $display("tb: %0d transfers in, %0d runs and %0d blocks checked, %0d mismatches",
                 sb.inputs_seen, sb.runs_seen, sb.blocks_seen, sb.errors);
        $display("tb: rates 64 to 1000000 samples/ms, captures from empty to full width");
        if (sb.errors == 0) $display("tb: PASS");
        else $display("tb: FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/tesp_pkg.sv
hw/rtl/tesp_front.sv
hw/rtl/tesp_queue.sv
hw/rtl/tesp_back.sv
hw/rtl/timestamped_event_to_sample_packer_top.sv
test/tb.sv
